FILE: rtl/bdmc_pkg.sv
// types, codes and reset values shared by the key debounce and mode control block
// no dependencies
`default_nettype none

package bdmc_pkg;

   localparam int unsigned NUM_KEYS = 4;

   // key positions in raw_keys
   localparam int unsigned KEY_STOP  = 0;
   localparam int unsigned KEY_MODE  = 1;
   localparam int unsigned KEY_YAW   = 2;
   localparam int unsigned KEY_PITCH = 3;

   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE_TIME   = 2'd0,
      CSR_LONG_PRESS_TIME = 2'd1,
      CSR_REPEAT_INTERVAL = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_INDEPENDENT = 2'd0,
      MODE_SPIN        = 2'd1,
      MODE_FOLLOW      = 2'd2
   } mode_type;

   localparam logic [CSR_DATA_W-1:0] DEBOUNCE_TIME_RESET   = 16'd20;
   localparam logic [CSR_DATA_W-1:0] LONG_PRESS_TIME_RESET = 16'd800;
   localparam logic [CSR_DATA_W-1:0] REPEAT_INTERVAL_RESET = 16'd200;

   typedef struct packed {
      logic [31:0]         now_ms;
      logic [NUM_KEYS-1:0] raw_keys;
   } req_payload_type;

   typedef struct packed {
      logic       run_enable;
      logic [1:0] base_mode;
      logic       yaw_step;
      logic       pitch_step;
      logic       stop_toggle;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: rtl/button_debounce_mode_control.sv
// Takes one tick (millisecond timestamp and four raw key levels) per transfer and returns one
// result per tick: one tick per clock cycle sustained unless the result side stalls, through
// the input register and the result register with all four keys updated side by side in
// between. Each key is debounced by time, short presses and long-press repeats are detected
// with wrapping 32-bit elapsed times, and the stop latch and drive mode follow the keys.
// Configuration (debounce, long-press and repeat times) must only be written while idle.
// depends on bdmc_pkg
`default_nettype none

module button_debounce_mode_control (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  bdmc_pkg::req_payload_type    req_payload,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output bdmc_pkg::rsp_payload_type          rsp_payload,
   input  wire                                csr_wr_en,
   input  wire  [bdmc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [bdmc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bdmc_pkg::*;

   // configuration
   logic [CSR_DATA_W-1:0] debounce_time_ff;
   logic [CSR_DATA_W-1:0] long_press_time_ff;
   logic [CSR_DATA_W-1:0] repeat_interval_ff;

   // input stage
   logic            in_valid_ff;
   req_payload_type in_data_ff;

   // result stage
   logic            out_valid_ff;
   rsp_payload_type out_data_ff;
   rsp_payload_type out_data_in;

   // per-key state
   logic [NUM_KEYS-1:0] key_last_raw_ff,  key_last_raw_in;
   logic [NUM_KEYS-1:0] key_stable_ff,    key_stable_in;
   logic [31:0]         key_change_ff     [NUM_KEYS];
   logic [31:0]         key_change_in     [NUM_KEYS];
   logic [31:0]         key_press_ff      [NUM_KEYS];
   logic [31:0]         key_press_in      [NUM_KEYS];
   logic [31:0]         key_repeat_ff     [NUM_KEYS];
   logic [31:0]         key_repeat_in     [NUM_KEYS];
   logic                stop_latched_ff,  stop_latched_in;
   mode_type            drive_mode_ff,    drive_mode_in;

   logic [NUM_KEYS-1:0] short_ev;
   logic [NUM_KEYS-1:0] repeat_ev;
   logic [NUM_KEYS-1:0] held_long;
   logic                fire;
   logic [31:0]         now;
   logic [31:0]         debounce_ext, long_ext, repeat_ext;

   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   assign now          = in_data_ff.now_ms;
   assign debounce_ext = {16'd0, debounce_time_ff};
   assign long_ext     = {16'd0, long_press_time_ff};
   assign repeat_ext   = {16'd0, repeat_interval_ff};

   always_comb begin
      logic       raw;
      logic       settled;
      logic       flip;
      logic [31:0] since_press;
      for (int k = 0; k < NUM_KEYS; k++) begin
         raw = in_data_ff.raw_keys[k];
         key_last_raw_in[k] = raw;
         key_change_in[k]   = (raw != key_last_raw_ff[k]) ? now : key_change_ff[k];
         settled = (now - key_change_in[k]) >= debounce_ext;
         flip    = settled && (raw != key_stable_ff[k]);
         key_stable_in[k] = settled ? raw : key_stable_ff[k];
         since_press = now - key_press_ff[k];
         // short event on a stable release before the long-press time
         short_ev[k] = flip && !raw && (since_press < long_ext);
         key_press_in[k]  = (flip && raw) ? now : key_press_ff[k];
         held_long[k] = key_stable_in[k] && ((now - key_press_in[k]) >= long_ext);
         // repeats only once the raw level has settled
         repeat_ev[k] = settled && held_long[k]
                        && ((now - ((flip && raw) ? now : key_repeat_ff[k])) >= repeat_ext);
         key_repeat_in[k] = ((flip && raw) || repeat_ev[k]) ? now : key_repeat_ff[k];
      end
   end

   always_comb begin
      stop_latched_in = short_ev[KEY_STOP] ? !stop_latched_ff : stop_latched_ff;
      drive_mode_in   = drive_mode_ff;
      if (short_ev[KEY_MODE]) begin
         drive_mode_in = (drive_mode_ff == MODE_SPIN) ? MODE_INDEPENDENT : MODE_SPIN;
      end
      // long hold of mode overrides; leaving follow falls back to independent
      if (held_long[KEY_MODE]) begin
         drive_mode_in = MODE_FOLLOW;
      end else if (drive_mode_in == MODE_FOLLOW) begin
         drive_mode_in = MODE_INDEPENDENT;
      end
      out_data_in.run_enable  = !stop_latched_in;
      out_data_in.base_mode   = drive_mode_in;
      out_data_in.yaw_step    = short_ev[KEY_YAW] || repeat_ev[KEY_YAW];
      out_data_in.pitch_step  = short_ev[KEY_PITCH] || repeat_ev[KEY_PITCH];
      out_data_in.stop_toggle = short_ev[KEY_STOP];
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_time_ff   <= DEBOUNCE_TIME_RESET;
         long_press_time_ff <= LONG_PRESS_TIME_RESET;
         repeat_interval_ff <= REPEAT_INTERVAL_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE_TIME:   debounce_time_ff   <= csr_wdata;
            CSR_LONG_PRESS_TIME: long_press_time_ff <= csr_wdata;
            CSR_REPEAT_INTERVAL: repeat_interval_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_payload;
      end
      if (fire) begin
         out_data_ff <= out_data_in;
      end
   end

   // key and mode state, updated once per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         key_last_raw_ff <= '0;
         key_stable_ff   <= '0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            key_change_ff[k] <= '0;
            key_press_ff[k]  <= '0;
            key_repeat_ff[k] <= '0;
         end
         stop_latched_ff <= 1'b1;
         drive_mode_ff   <= MODE_INDEPENDENT;
      end else if (fire) begin
         key_last_raw_ff <= key_last_raw_in;
         key_stable_ff   <= key_stable_in;
         for (int k = 0; k < NUM_KEYS; k++) begin
            key_change_ff[k] <= key_change_in[k];
            key_press_ff[k]  <= key_press_in[k];
            key_repeat_ff[k] <= key_repeat_in[k];
         end
         stop_latched_ff <= stop_latched_in;
         drive_mode_ff   <= drive_mode_in;
      end
   end

   // result loaded this cycle reflects the stop latch it left behind
   a_run_enable_matches: assert property (@(posedge clock) disable iff (reset)
      $past(fire) |-> (rsp_payload.run_enable == !stop_latched_ff))
      else $error("run_enable does not match stop latch");

   // a held result freezes the control state
   a_state_frozen_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(stop_latched_ff) && $stable(drive_mode_ff)))
      else $error("state moved while result stalled");

   // follow-gimbal only while the mode key is stably pressed
   a_follow_needs_key: assert property (@(posedge clock) disable iff (reset)
      (drive_mode_ff == MODE_FOLLOW) |-> key_stable_ff[KEY_MODE])
      else $error("follow mode without mode key held");

   // stall on the request side only when the input and result stages are both full
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff))
      else $error("request stalled with room available");

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// self-checking bench for button_debounce_mode_control: directed and random keys vs a predictor
// depends on bdmc_pkg and the block under test only

module tb;
   import bdmc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD_CYCLES = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam logic [NUM_KEYS-1:0] KEYS_NONE  = '0;
   localparam logic [NUM_KEYS-1:0] KEYS_ALL   = '1;
   localparam logic [NUM_KEYS-1:0] KEYS_MODE  = 4'b1 << KEY_MODE;
   localparam logic [NUM_KEYS-1:0] KEYS_YAW   = 4'b1 << KEY_YAW;
   localparam logic [NUM_KEYS-1:0] KEYS_PITCH = 4'b1 << KEY_PITCH;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   button_debounce_mode_control dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #4 clock = ~clock;

   // predictor state
   logic            key_raw_seen  [NUM_KEYS];
   logic [31:0]     key_change_ms [NUM_KEYS];
   logic            key_level     [NUM_KEYS];
   logic [31:0]     key_down_ms   [NUM_KEYS];
   logic [31:0]     key_rep_ms    [NUM_KEYS];
   logic            stopped;
   mode_type        chassis;
   logic [15:0]     cfg_debounce, cfg_long_press, cfg_repeat;

   req_payload_type pending_ticks [$];
   rsp_payload_type expected_results [$];

   int ticks_queued = 0;
   int results_seen = 0;
   int fail_count = 0;
   int settings_used = 1;
   int stop_toggles = 0;
   int step_flags = 0;
   int follow_results = 0;
   int send_idle_pct = 27;
   int take_idle_pct = 55;
   int quiet_cycles = 0;
   int hold_left = 0;
   logic long_hold_req = 1'b0;
   logic long_hold_done = 1'b0;
   logic req_taken = 1'b0;
   logic [31:0] gen_now = '0;
   logic [NUM_KEYS-1:0] gen_keys = '0;

   task automatic clear_predictor();
      int k;
      for (k = 0; k < NUM_KEYS; k++) begin
         key_raw_seen[k]  = 1'b0;
         key_change_ms[k] = '0;
         key_level[k]     = 1'b0;
         key_down_ms[k]   = '0;
         key_rep_ms[k]    = '0;
      end
      stopped        = 1'b1;
      chassis        = MODE_INDEPENDENT;
      cfg_debounce   = DEBOUNCE_TIME_RESET;
      cfg_long_press = LONG_PRESS_TIME_RESET;
      cfg_repeat     = REPEAT_INTERVAL_RESET;
   endtask

   task automatic debounce_tick(input req_payload_type tick, output rsp_payload_type res);
      logic [NUM_KEYS-1:0] short_press, repeat_hit;
      logic [31:0] now;
      logic raw, emerg;
      int k;
      now = tick.now_ms;
      short_press = '0;
      repeat_hit = '0;
      emerg = 1'b0;
      for (k = 0; k < NUM_KEYS; k++) begin
         raw = tick.raw_keys[k];
         if (raw != key_raw_seen[k]) begin
            key_raw_seen[k] = raw;
            key_change_ms[k] = now;
         end
         // elapsed times are 32-bit and wrap
         if (now - key_change_ms[k] >= cfg_debounce) begin
            if (raw != key_level[k]) begin
               key_level[k] = raw;
               if (raw) begin
                  key_down_ms[k] = now;
                  key_rep_ms[k] = now;
               end else if (now - key_down_ms[k] < cfg_long_press) begin
                  short_press[k] = 1'b1;
               end
            end
            if (key_level[k] && now - key_down_ms[k] >= cfg_long_press &&
                now - key_rep_ms[k] >= cfg_repeat) begin
               repeat_hit[k] = 1'b1;
               key_rep_ms[k] = now;
            end
         end
      end
      if (short_press[KEY_STOP]) begin
         stopped = ~stopped;
         emerg = 1'b1;
      end
      if (short_press[KEY_MODE]) begin
         chassis = (chassis == MODE_SPIN) ? MODE_INDEPENDENT : MODE_SPIN;
      end
      // long hold uses this tick's stable level, even mid-bounce
      if (key_level[KEY_MODE] && now - key_down_ms[KEY_MODE] >= cfg_long_press) begin
         chassis = MODE_FOLLOW;
      end else if (chassis == MODE_FOLLOW) begin
         chassis = MODE_INDEPENDENT;
      end
      res.run_enable  = ~stopped;
      res.base_mode   = chassis;
      res.yaw_step    = short_press[KEY_YAW] | repeat_hit[KEY_YAW];
      res.pitch_step  = short_press[KEY_PITCH] | repeat_hit[KEY_PITCH];
      res.stop_toggle = emerg;
   endtask

   task automatic check_field(input string field, input logic [1:0] want, input logic [1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   // input side: predict on every accepted transfer
   // result side: compare against the oldest prediction
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            debounce_tick(req_payload, want);
            expected_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $error("unexpected result transfer: %p", rsp_payload);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("run_enable", 2'(want.run_enable), 2'(rsp_payload.run_enable));
               check_field("base_mode", want.base_mode, rsp_payload.base_mode);
               check_field("yaw_step", 2'(want.yaw_step), 2'(rsp_payload.yaw_step));
               check_field("pitch_step", 2'(want.pitch_step), 2'(rsp_payload.pitch_step));
               check_field("stop_toggle", 2'(want.stop_toggle),
                           2'(rsp_payload.stop_toggle));
               stop_toggles += int'(want.stop_toggle);
               step_flags += int'(want.yaw_step) + int'(want.pitch_step);
               if (want.base_mode == MODE_FOLLOW) follow_results++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // sender: payload held until the transfer happens
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_ticks.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_payload <= pending_ticks.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (long_hold_req && !long_hold_done) begin
            hold_left = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < take_idle_pct);
         end
      end
   end

   task automatic queue_tick(input logic [31:0] now, input logic [NUM_KEYS-1:0] keys);
      req_payload_type tick;
      tick.now_ms = now;
      tick.raw_keys = keys;
      pending_ticks.push_back(tick);
      ticks_queued++;
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (results_seen != ticks_queued);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_DEBOUNCE_TIME:   cfg_debounce = value;
         CSR_LONG_PRESS_TIME: cfg_long_press = value;
         CSR_REPEAT_INTERVAL: cfg_repeat = value;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic apply_times(input logic [15:0] db, input logic [15:0] lp, input logic [15:0] rp);
      write_csr(CSR_DEBOUNCE_TIME, db);
      write_csr(CSR_LONG_PRESS_TIME, lp);
      write_csr(CSR_REPEAT_INTERVAL, rp);
      settings_used++;
   endtask

   function automatic logic [31:0] hold_step(input logic [31:0] db, input logic [31:0] lp,
                                             input logic [31:0] rp);
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, db);
         1: return db + $urandom_range(0, rp);
         2: return $urandom_range(0, rp + 1);
         3: return $urandom_range(lp / 2, lp + rp);
         default: return $urandom_range(0, 3);
      endcase
   endfunction

   // mostly press/release episodes with bounce, some arbitrary jumps in time
   task automatic queue_key_episodes(input int total);
      int made, bounces, holds, i;
      logic [NUM_KEYS-1:0] target;
      logic [31:0] db, lp, rp;
      db = cfg_debounce;
      lp = cfg_long_press;
      rp = cfg_repeat;
      made = 0;
      gen_now = $urandom;
      while (made < total) begin
         if ($urandom_range(0, 9) == 0) begin
            gen_now = $urandom;
            gen_keys = NUM_KEYS'($urandom);
            queue_tick(gen_now, gen_keys);
            made++;
         end else begin
            if ($urandom_range(0, 1)) target = NUM_KEYS'($urandom);
            else target = gen_keys ^ (4'b0001 << $urandom_range(0, NUM_KEYS - 1));
            bounces = (db > 1) ? $urandom_range(0, 3) : 0;
            for (i = 0; i < bounces; i++) begin
               gen_now += $urandom_range(0, db - 1);
               queue_tick(gen_now, i[0] ? gen_keys : target);
               made++;
            end
            holds = $urandom_range(1, 8);
            for (i = 0; i < holds; i++) begin
               gen_now += hold_step(db, lp, rp);
               queue_tick(gen_now, target);
               made++;
            end
            gen_keys = target;
         end
      end
   endtask

   initial begin
      clear_predictor();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset timings: bounce, short press of every key, long mode hold, yaw repeats
      queue_tick(32'd0, KEYS_NONE);
      queue_tick(32'd5, KEYS_ALL);
      queue_tick(32'd10, KEYS_NONE);
      queue_tick(32'd12, KEYS_ALL);
      queue_tick(32'd40, KEYS_ALL);
      queue_tick(32'd100, KEYS_NONE);
      queue_tick(32'd130, KEYS_NONE);
      queue_tick(32'd200, KEYS_MODE);
      queue_tick(32'd230, KEYS_MODE);
      queue_tick(32'd1030, KEYS_MODE);
      queue_tick(32'd1100, KEYS_NONE);
      queue_tick(32'd1130, KEYS_NONE);
      queue_tick(32'd1200, KEYS_YAW);
      queue_tick(32'd1220, KEYS_YAW);
      queue_tick(32'd2020, KEYS_YAW);
      queue_tick(32'd2100, KEYS_YAW);
      queue_tick(32'd2220, KEYS_YAW);
      queue_tick(32'd2240, KEYS_NONE);
      queue_tick(32'd2260, KEYS_NONE);
      // pitch press across the timestamp wrap, then time running backwards
      queue_tick(32'hFFFF_FFF0, KEYS_PITCH);
      queue_tick(32'h0000_0010, KEYS_PITCH);
      queue_tick(32'h0000_0030, KEYS_NONE);
      queue_tick(32'h0000_0050, KEYS_NONE);
      queue_tick(32'hFFFF_FFFF, KEYS_ALL);
      wait_drained();

      apply_times(16'd3, 16'd40, 16'd10);
      queue_key_episodes(600);
      wait_drained();

      send_idle_pct = 55;
      take_idle_pct = 27;
      apply_times(16'd0, 16'd0, 16'd0);
      // unused register index must leave the timings alone
      write_csr(CSR_UNUSED, 16'hFFFF);
      queue_key_episodes(300);
      wait_drained();

      apply_times(16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_key_episodes(300);
      wait_drained();

      send_idle_pct = 0;
      take_idle_pct = 0;
      apply_times(16'($urandom_range(0, 40)), 16'($urandom_range(0, 400)),
                  16'($urandom_range(0, 80)));
      queue_key_episodes(300);
      // receiver holds off while the sender keeps offering
      long_hold_req = 1'b1;
      wait_drained();
      queue_key_episodes(300);
      wait_drained();

      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         fail_count++;
      end
      $display("%0d ticks checked over %0d timing settings (reset, small, zero, max, random)",
               results_seen, settings_used);
      $display("%0d stop toggles, %0d yaw/pitch steps, %0d follow-gimbal results",
               stop_toggles, step_flags, follow_results);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
